>>> hdl/scale_calibration_stability_sequencer_macros.svh
// Assertion macros shared by the scale calibration sequencer RTL.
`ifndef SCALE_CALIBRATION_STABILITY_SEQUENCER_MACROS_SVH
`define SCALE_CALIBRATION_STABILITY_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ssc_pkg.sv
// Package with types, constants and helpers of the scale calibration sequencer.
`default_nettype none
package ssc_pkg;

   localparam int DELTA_WIDTH = 26;
   localparam int CFG_WIDTH   = 25;
   localparam int COUNT_WIDTH = 8;
   localparam int WEIGHT_WIDTH = 16;
   localparam int MAG_WIDTH   = (DELTA_WIDTH + 1 > CFG_WIDTH) ? DELTA_WIDTH + 1 : CFG_WIDTH;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [DELTA_WIDTH-1:0] delta_type;
   typedef logic        [DELTA_WIDTH-1:0] dmag_type;
   typedef logic signed [DELTA_WIDTH:0]   wide_type;
   typedef logic        [DELTA_WIDTH:0]   wmag_type;
   typedef logic        [MAG_WIDTH-1:0]   cmp_type;
   typedef logic        [COUNT_WIDTH-1:0] count_type;

   // Request codes as they arrive on the input channel
   typedef enum logic [1:0] {
      KIND_SELECT    = 2'd0,
      KIND_TARE_DONE = 2'd1,
      KIND_SAMPLE    = 2'd2,
      KIND_RESTART   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      PH_WAIT_TARE   = 4'b0001,
      PH_TARING      = 4'b0010,
      PH_WAIT_WEIGHT = 4'b0100,
      PH_DONE        = 4'b1000
   } phase_type;

   localparam logic [1:0] PHASE_CODE_WAIT_TARE   = 2'd0;
   localparam logic [1:0] PHASE_CODE_TARING      = 2'd1;
   localparam logic [1:0] PHASE_CODE_WAIT_WEIGHT = 2'd2;
   localparam logic [1:0] PHASE_CODE_DONE        = 2'd3;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]    min_delta;
      logic [CFG_WIDTH-1:0]    stable_tolerance;
      logic [COUNT_WIDTH-1:0]  stable_target;
      logic [WEIGHT_WIDTH-1:0] known_weight_grams;
   } cfg_type;

   // Classified transaction handed from the front end to the back end
   typedef struct packed {
      kind_type  kind;
      logic      below_min;
      delta_type delta;
   } item_type;

   function automatic logic [1:0] phase_encode(input phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_WAIT_TARE:   code = PHASE_CODE_WAIT_TARE;
         PH_TARING:      code = PHASE_CODE_TARING;
         PH_WAIT_WEIGHT: code = PHASE_CODE_WAIT_WEIGHT;
         PH_DONE:        code = PHASE_CODE_DONE;
         default:        code = PHASE_CODE_WAIT_TARE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

>>> hdl/ssc_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface ssc_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   ssc_pkg::delta_type   raw_delta;

   modport source (output valid, output req_type, output raw_delta, input ready);
   modport sink   (input valid, input req_type, input raw_delta, output ready);
endinterface

interface ssc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            phase;
   logic                                  tare_request;
   logic                                  calibrate_command;
   logic [ssc_pkg::WEIGHT_WIDTH-1:0]      calibrate_weight;
   ssc_pkg::delta_type                    running_value;
   ssc_pkg::count_type                    consistent_count;
   logic                                  screen_change;

   modport source (output valid, output phase, output tare_request,
                   output calibrate_command, output calibrate_weight,
                   output running_value, output consistent_count,
                   output screen_change, input ready);
   modport sink   (input valid, input phase, input tare_request,
                   input calibrate_command, input calibrate_weight,
                   input running_value, input consistent_count,
                   input screen_change, output ready);
endinterface
`default_nettype wire

>>> hdl/ssc_front.sv
// Front end: accepts request transactions and classifies them for the back end.
`default_nettype none
module ssc_front (
   ssc_req_if.sink                             req_port,
   input  wire logic [ssc_pkg::CFG_WIDTH-1:0]  min_delta,
   input  wire logic                           push_ready,
   output      logic                           push_valid,
   output      ssc_pkg::item_type              push_item
);

   ssc_pkg::dmag_type raw_mag;

   // Magnitude of the most negative code is still exact as an unsigned value
   assign raw_mag = req_port.raw_delta[ssc_pkg::DELTA_WIDTH-1]
                    ? ssc_pkg::dmag_type'(-req_port.raw_delta)
                    : ssc_pkg::dmag_type'(req_port.raw_delta);

   assign push_valid          = req_port.valid;
   assign req_port.ready      = push_ready;
   assign push_item.kind      = ssc_pkg::kind_type'(req_port.req_type);
   assign push_item.delta     = req_port.raw_delta;
   assign push_item.below_min = ssc_pkg::cmp_type'(raw_mag) < ssc_pkg::cmp_type'(min_delta);

endmodule
`default_nettype wire

>>> hdl/ssc_queue.sv
// Short queue between the front end and the back end.
`default_nettype none
module ssc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire ssc_pkg::item_type push_item,
   output      logic              push_ready,
   output      logic              pop_valid,
   output      ssc_pkg::item_type pop_item,
   input  wire logic              pop_ready
);

   ssc_pkg::item_type                  entries_ff [ssc_pkg::QUEUE_DEPTH];
   logic [ssc_pkg::QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ssc_pkg::QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ssc_pkg::QCNT_WIDTH-1:0]     count_ff, count_in;
   logic                               push;
   logic                               pop;

   assign push_ready = count_ff != ssc_pkg::QCNT_WIDTH'(ssc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ssc_pkg::QPTR_WIDTH'(ssc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ssc_pkg::QPTR_WIDTH'(ssc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> hdl/ssc_back.sv
// Back end: phase sequencer, stability detector and registered response.
`default_nettype none
module ssc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ssc_pkg::cfg_type  cfg,
   input  wire logic              pop_valid,
   input  wire ssc_pkg::item_type pop_item,
   output      logic              pop_ready,
   ssc_rsp_if.source              rsp_port
);

   ssc_pkg::phase_type phase_ff, phase_in;
   ssc_pkg::delta_type avg_ff, avg_in;
   ssc_pkg::count_type count_ff, count_in;
   ssc_pkg::count_type count_inc;
   logic               tare_pulse;
   logic               cal_pulse;
   logic               take;

   ssc_pkg::wide_type  diff;
   ssc_pkg::wmag_type  diff_mag;
   logic               far_off;
   ssc_pkg::wide_type  sum;
   ssc_pkg::wide_type  sum_adj;
   ssc_pkg::delta_type mean;

   logic                                rsp_valid_ff;
   logic [1:0]                          rsp_phase_ff;
   logic                                rsp_tare_ff;
   logic                                rsp_cal_ff;
   logic [ssc_pkg::WEIGHT_WIDTH-1:0]    rsp_weight_ff;
   ssc_pkg::delta_type                  rsp_avg_ff;
   ssc_pkg::count_type                  rsp_count_ff;
   logic                                rsp_change_ff;

   // Take a transaction whenever the output register is empty or draining
   assign take      = pop_valid && (!rsp_valid_ff || rsp_port.ready);
   assign pop_ready = !rsp_valid_ff || rsp_port.ready;

   assign diff     = ssc_pkg::wide_type'(pop_item.delta) - ssc_pkg::wide_type'(avg_ff);
   assign diff_mag = diff[ssc_pkg::DELTA_WIDTH] ? ssc_pkg::wmag_type'(-diff)
                                                : ssc_pkg::wmag_type'(diff);
   assign far_off  = ssc_pkg::cmp_type'(diff_mag) > ssc_pkg::cmp_type'(cfg.stable_tolerance);

   // Mean truncated toward zero: bias negative sums up by one before halving
   assign sum     = ssc_pkg::wide_type'(pop_item.delta) + ssc_pkg::wide_type'(avg_ff);
   assign sum_adj = sum + ssc_pkg::wide_type'({1'b0, sum[ssc_pkg::DELTA_WIDTH]});
   assign mean    = sum_adj[ssc_pkg::DELTA_WIDTH:1];

   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      avg_in     = avg_ff;
      count_in   = count_ff;
      tare_pulse = 1'b0;
      cal_pulse  = 1'b0;
      case (pop_item.kind)
         ssc_pkg::KIND_SELECT: begin
            if (phase_ff == ssc_pkg::PH_WAIT_TARE) begin
               tare_pulse = 1'b1;
               phase_in   = ssc_pkg::PH_TARING;
            end
         end
         ssc_pkg::KIND_TARE_DONE: begin
            if (phase_ff == ssc_pkg::PH_TARING) begin
               phase_in = ssc_pkg::PH_WAIT_WEIGHT;
               avg_in   = '0;
               count_in = '0;
            end
         end
         ssc_pkg::KIND_SAMPLE: begin
            if (phase_ff == ssc_pkg::PH_WAIT_WEIGHT) begin
               if (pop_item.below_min) begin
                  avg_in   = '0;
                  count_in = '0;
               end else if (count_ff == '0 || far_off) begin
                  // Restart the detector at this sample
                  avg_in   = pop_item.delta;
                  count_in = ssc_pkg::count_type'(1);
               end else begin
                  avg_in   = mean;
                  count_in = count_inc;
                  if (count_inc >= cfg.stable_target) begin
                     cal_pulse = 1'b1;
                     phase_in  = ssc_pkg::PH_DONE;
                  end
               end
            end
         end
         ssc_pkg::KIND_RESTART: begin
            phase_in = ssc_pkg::PH_WAIT_TARE;
            avg_in   = '0;
            count_in = '0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ssc_pkg::PH_WAIT_TARE;
         avg_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            avg_ff   <= avg_in;
            count_ff <= count_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_phase_ff  <= ssc_pkg::phase_encode(phase_in);
         rsp_tare_ff   <= tare_pulse;
         rsp_cal_ff    <= cal_pulse;
         rsp_weight_ff <= cal_pulse ? cfg.known_weight_grams : '0;
         rsp_avg_ff    <= avg_in;
         rsp_count_ff  <= count_in;
         rsp_change_ff <= phase_in != phase_ff;
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.phase             = rsp_phase_ff;
   assign rsp_port.tare_request      = rsp_tare_ff;
   assign rsp_port.calibrate_command = rsp_cal_ff;
   assign rsp_port.calibrate_weight  = rsp_weight_ff;
   assign rsp_port.running_value     = rsp_avg_ff;
   assign rsp_port.consistent_count  = rsp_count_ff;
   assign rsp_port.screen_change     = rsp_change_ff;

endmodule
`default_nettype wire

>>> hdl/scale_calibration_stability_sequencer.sv
// Top level of the scale calibration sequencer: register port, front end, queue, back end.
//
// Requests arrive on req_port (valid/ready): select, tare finished, timed sample or
// restart, with a signed raw delta used by samples only. Every request yields exactly
// one response on rsp_port: the phase after the step, the tare and calibrate pulses,
// the calibrate weight, the running value, the consistent count and a screen-change flag.
// A request passes through a queue entry and then the output register before its response
// is presented; throughput is one transaction per cycle while the receiver is ready,
// as the back-end state updates with every accepted transaction.
// A two-entry queue separates the front end from the back end, and the response sits
// in an output register, so a new request is still taken while a response waits.
// When the receiver stalls, the output register holds, the queue fills, and req ready
// drops once both queue entries are occupied.
// Four registers (minimum delta, tolerance, target, known weight) are written through
// the APB-style port at byte addresses 0, 4, 8 and 12; write them only while idle.
// Synchronous reset returns the phase to wait-for-tare, clears the detector, empties
// the queue and loads the register defaults.
`default_nettype none
`include "scale_calibration_stability_sequencer_macros.svh"
module scale_calibration_stability_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready,
   ssc_req_if.sink          req_port,
   ssc_rsp_if.source        rsp_port
);

   localparam logic [1:0] CSR_MIN_DELTA    = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE    = 2'd1;
   localparam logic [1:0] CSR_TARGET       = 2'd2;
   localparam logic [1:0] CSR_KNOWN_WEIGHT = 2'd3;

   ssc_pkg::cfg_type  cfg_ff;
   logic              csr_write;
   logic [1:0]        csr_index;

   logic              push_valid;
   logic              push_ready;
   ssc_pkg::item_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   ssc_pkg::item_type pop_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_delta          <= ssc_pkg::CFG_WIDTH'(1000);
         cfg_ff.stable_tolerance   <= ssc_pkg::CFG_WIDTH'(200);
         cfg_ff.stable_target      <= ssc_pkg::COUNT_WIDTH'(5);
         cfg_ff.known_weight_grams <= ssc_pkg::WEIGHT_WIDTH'(1000);
      end else if (csr_write) begin
         case (csr_index)
            CSR_MIN_DELTA:    cfg_ff.min_delta <= pwdata[ssc_pkg::CFG_WIDTH-1:0];
            CSR_TOLERANCE:    cfg_ff.stable_tolerance <= pwdata[ssc_pkg::CFG_WIDTH-1:0];
            CSR_TARGET:       cfg_ff.stable_target <= pwdata[ssc_pkg::COUNT_WIDTH-1:0];
            CSR_KNOWN_WEIGHT: cfg_ff.known_weight_grams <= pwdata[ssc_pkg::WEIGHT_WIDTH-1:0];
            default:          cfg_ff.min_delta <= cfg_ff.min_delta;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_MIN_DELTA:    prdata = 32'(cfg_ff.min_delta);
         CSR_TOLERANCE:    prdata = 32'(cfg_ff.stable_tolerance);
         CSR_TARGET:       prdata = 32'(cfg_ff.stable_target);
         CSR_KNOWN_WEIGHT: prdata = 32'(cfg_ff.known_weight_grams);
         default:          prdata = '0;
      endcase
   end

   ssc_front u_front (
      .req_port   (req_port),
      .min_delta  (cfg_ff.min_delta),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   ssc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_port  (rsp_port)
   );

   `SSC_ASSERT_NOW(a_cal_enters_done, clock, reset,
      rsp_port.valid && rsp_port.calibrate_command,
      rsp_port.phase == ssc_pkg::PHASE_CODE_DONE && rsp_port.screen_change,
      "calibrate command without a move to the done phase")
   `SSC_ASSERT_NOW(a_tare_enters_taring, clock, reset,
      rsp_port.valid && rsp_port.tare_request,
      rsp_port.phase == ssc_pkg::PHASE_CODE_TARING && rsp_port.screen_change,
      "tare request without a move to the taring phase")
   `SSC_ASSERT_NOW(a_weight_only_on_cal, clock, reset,
      rsp_port.valid && !rsp_port.calibrate_command,
      rsp_port.calibrate_weight == '0,
      "calibrate weight set without a calibrate command")
   `SSC_ASSERT_NEXT(a_accept_gives_response, clock, reset,
      req_port.valid && req_port.ready && !rsp_port.valid,
      pop_valid || rsp_port.valid,
      "accepted request vanished before reaching the back end")

endmodule
`default_nettype wire

>>> verif/scale_calibration_stability_sequencer_tb.sv
// Testbench for the scale calibration sequencer: stimulus, prediction and result checks.
module scale_calibration_stability_sequencer_tb;

   localparam int     WATCHDOG_LIMIT = 3000;
   localparam longint DELTA_MAX      = 33554431;
   localparam longint DELTA_MIN      = -33554432;
   localparam longint CFG_MAX        = 33554431;

   localparam logic [3:0] ADDR_MIN_DELTA = 4'd0;
   localparam logic [3:0] ADDR_TOLERANCE = 4'd4;
   localparam logic [3:0] ADDR_TARGET    = 4'd8;
   localparam logic [3:0] ADDR_WEIGHT    = 4'd12;

   typedef struct packed {
      logic [1:0]                       phase;
      logic                             tare_request;
      logic                             calibrate_command;
      logic [ssc_pkg::WEIGHT_WIDTH-1:0] calibrate_weight;
      ssc_pkg::delta_type               running_value;
      ssc_pkg::count_type               consistent_count;
      logic                             screen_change;
   } step_result_type;

   class calibration_scoreboard_type;
      ssc_pkg::cfg_type   regs;
      logic [1:0]         phase;
      ssc_pkg::delta_type avg;
      ssc_pkg::count_type count;
      step_result_type    expected_steps[$];
      int                 errors;
      int                 checked;
      int                 calibrations;

      function new();
         regs.min_delta          = 25'd1000;
         regs.stable_tolerance   = 25'd200;
         regs.stable_target      = 8'd5;
         regs.known_weight_grams = 16'd1000;
         phase = ssc_pkg::PHASE_CODE_WAIT_TARE;
         avg   = '0;
         count = '0;
      endfunction

      static function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function void set_register(logic [3:0] addr, logic [31:0] data);
         case (addr)
            ADDR_MIN_DELTA: regs.min_delta          = data[ssc_pkg::CFG_WIDTH-1:0];
            ADDR_TOLERANCE: regs.stable_tolerance   = data[ssc_pkg::CFG_WIDTH-1:0];
            ADDR_TARGET:    regs.stable_target      = data[ssc_pkg::COUNT_WIDTH-1:0];
            ADDR_WEIGHT:    regs.known_weight_grams = data[ssc_pkg::WEIGHT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // Advance the predicted sequencer state by one accepted request.
      function void take_request(ssc_pkg::kind_type kind, ssc_pkg::delta_type delta);
         step_result_type r;
         logic [1:0]      prior;
         longint          d;
         longint          a;
         r     = '0;
         prior = phase;
         d     = delta;
         a     = avg;
         case (kind)
            ssc_pkg::KIND_SELECT:
               if (phase == ssc_pkg::PHASE_CODE_WAIT_TARE) begin
                  r.tare_request = 1'b1;
                  phase = ssc_pkg::PHASE_CODE_TARING;
               end
            ssc_pkg::KIND_TARE_DONE:
               if (phase == ssc_pkg::PHASE_CODE_TARING) begin
                  phase = ssc_pkg::PHASE_CODE_WAIT_WEIGHT;
                  avg   = '0;
                  count = '0;
               end
            ssc_pkg::KIND_SAMPLE:
               if (phase == ssc_pkg::PHASE_CODE_WAIT_WEIGHT) begin
                  if (magnitude(d) < longint'(regs.min_delta)) begin
                     avg   = '0;
                     count = '0;
                  end else if (count == 0 ||
                               magnitude(d - a) > longint'(regs.stable_tolerance)) begin
                     avg   = delta;
                     count = 8'd1;
                  end else begin
                     // signed division truncates toward zero
                     avg = ssc_pkg::delta_type'((a + d) / 2);
                     if (count != 8'd255) count = count + 8'd1;
                     if (count >= regs.stable_target) begin
                        r.calibrate_command = 1'b1;
                        r.calibrate_weight  = regs.known_weight_grams;
                        phase = ssc_pkg::PHASE_CODE_DONE;
                     end
                  end
               end
            default: begin
               phase = ssc_pkg::PHASE_CODE_WAIT_TARE;
               avg   = '0;
               count = '0;
            end
         endcase
         r.phase            = phase;
         r.running_value    = avg;
         r.consistent_count = count;
         r.screen_change    = (phase != prior);
         expected_steps.push_back(r);
      endfunction

      function void compare_field(string name, longint want, longint seen);
         if (want != seen) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_step(step_result_type seen);
         step_result_type want;
         if (expected_steps.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, actual phase %0d",
                     $time, seen.phase);
            errors++;
            return;
         end
         want = expected_steps.pop_front();
         checked++;
         if (want.calibrate_command) calibrations++;
         compare_field("phase", want.phase, seen.phase);
         compare_field("tare_request", want.tare_request, seen.tare_request);
         compare_field("calibrate_command", want.calibrate_command, seen.calibrate_command);
         compare_field("calibrate_weight", want.calibrate_weight, seen.calibrate_weight);
         compare_field("running_value", longint'(want.running_value),
                       longint'(seen.running_value));
         compare_field("consistent_count", want.consistent_count, seen.consistent_count);
         compare_field("screen_change", want.screen_change, seen.screen_change);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ssc_req_if req_bus ();
   ssc_rsp_if rsp_bus ();

   scale_calibration_stability_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   calibration_scoreboard_type sb = new();
   step_result_type            seen_step;
   int                         items_sent;
   int                         idle_cycles;
   int                         rsp_stall_left;
   int                         rsp_cycle;
   bit                         req_quiet;
   bit                         rsp_quiet;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Receiver: stall at random, with stretches of constant readiness.
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 300 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) rsp_stall_left = pick_gap(rsp_quiet);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_step.phase             = rsp_bus.phase;
         seen_step.tare_request      = rsp_bus.tare_request;
         seen_step.calibrate_command = rsp_bus.calibrate_command;
         seen_step.calibrate_weight  = rsp_bus.calibrate_weight;
         seen_step.running_value     = rsp_bus.running_value;
         seen_step.consistent_count  = rsp_bus.consistent_count;
         seen_step.screen_change     = rsp_bus.screen_change;
         sb.check_step(seen_step);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(ssc_pkg::kind_type kind, ssc_pkg::delta_type delta);
      int gap;
      gap = ($urandom_range(0, 99) < 35) ? pick_gap(req_quiet) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid     <= 1'b0;
         req_bus.req_type  <= 2'($urandom);
         req_bus.raw_delta <= ssc_pkg::delta_type'($urandom);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.raw_delta <= delta;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_request(kind, delta);
      items_sent++;
   endtask

   task automatic send_noise();
      send_item(ssc_pkg::kind_type'($urandom_range(0, 3)), ssc_pkg::delta_type'($urandom));
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_steps.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(addr, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Restart (usually), tare, then a run of samples around one level, with some disturbance.
   task automatic run_calibration();
      longint base;
      longint spread;
      longint v;
      longint half_tol;
      int     need;
      int     r;
      r = $urandom_range(0, 9);
      if (r < 7) send_item(ssc_pkg::KIND_RESTART, ssc_pkg::delta_type'($urandom));
      else if (r == 7) send_noise();
      send_item(ssc_pkg::KIND_SELECT, ssc_pkg::delta_type'($urandom));
      send_item(ssc_pkg::KIND_TARE_DONE, ssc_pkg::delta_type'($urandom));
      need = (sb.regs.stable_target < 2) ? 2 : int'(sb.regs.stable_target);
      need = need + $urandom_range(0, 4);
      base = $urandom_range(int'(sb.regs.min_delta), int'(DELTA_MAX));
      if ($urandom_range(0, 1)) base = -base;
      if ($urandom_range(0, 15) == 0) base = DELTA_MIN;
      half_tol = longint'(sb.regs.stable_tolerance) / 2;
      spread   = ($urandom_range(0, 1) || half_tol < 1000) ? half_tol : 1000;
      for (int i = 0; i < need && sb.phase != ssc_pkg::PHASE_CODE_DONE; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item($urandom_range(0, 1) ? ssc_pkg::KIND_SELECT : ssc_pkg::KIND_TARE_DONE,
                      ssc_pkg::delta_type'($urandom));
         end else if (r < 8) begin
            send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'($urandom));
         end else begin
            v = base + longint'($urandom_range(0, int'(2 * spread))) - spread;
            if (v > DELTA_MAX) v = DELTA_MAX;
            if (v < DELTA_MIN) v = DELTA_MIN;
            // keep the sample above the presence threshold
            if (calibration_scoreboard_type::magnitude(v) < longint'(sb.regs.min_delta))
               v = base;
            send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(v));
         end
      end
      if ($urandom_range(0, 3) == 0) send_noise();
   endtask

   task automatic run_random(int quota);
      int start;
      bit paused;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 9) == 0) req_quiet = ~req_quiet;
         if ($urandom_range(0, 9) < 8) run_calibration();
         else repeat ($urandom_range(1, 6)) send_noise();
         if (!paused && items_sent - start >= quota / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = ssc_pkg::KIND_SELECT;
      req_bus.raw_delta = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: events in the wrong phase, delta extremes, presence threshold,
      // tolerance edge, truncation toward zero, calibration and restart from done.
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(DELTA_MAX));
      send_item(ssc_pkg::KIND_TARE_DONE, '0);
      send_item(ssc_pkg::KIND_RESTART, '0);
      send_item(ssc_pkg::KIND_SELECT, '0);
      send_item(ssc_pkg::KIND_SELECT, '0);
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(5000));
      send_item(ssc_pkg::KIND_TARE_DONE, '0);
      send_item(ssc_pkg::KIND_SELECT, '0);
      send_item(ssc_pkg::KIND_TARE_DONE, '0);
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(DELTA_MAX));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(DELTA_MAX));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(DELTA_MIN));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(DELTA_MIN + 100));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(999));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(-1000));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(-801));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(-1101));
      repeat (4) send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(-1101));
      send_item(ssc_pkg::KIND_SAMPLE, ssc_pkg::delta_type'(-1101));
      send_item(ssc_pkg::KIND_SELECT, '0);
      send_item(ssc_pkg::KIND_TARE_DONE, '0);
      send_item(ssc_pkg::KIND_RESTART, '0);
      run_random(250);

      for (int set = 1; set <= 5; set++) begin
         drain();
         req_quiet = ($urandom_range(0, 3) == 0);
         case (set)
            1: begin
               write_reg(ADDR_MIN_DELTA, 32'd0);
               write_reg(ADDR_TOLERANCE, 32'd0);
               write_reg(ADDR_TARGET, 32'd1);
               write_reg(ADDR_WEIGHT, 32'd1);
            end
            2: begin
               write_reg(ADDR_MIN_DELTA, 32'(CFG_MAX));
               write_reg(ADDR_TOLERANCE, 32'(CFG_MAX));
               write_reg(ADDR_TARGET, 32'd255);
               write_reg(ADDR_WEIGHT, 32'd65535);
            end
            3: begin
               // a zero target behaves like a target of one
               write_reg(ADDR_MIN_DELTA, $urandom_range(0, 5000));
               write_reg(ADDR_TOLERANCE, $urandom_range(0, 2000));
               write_reg(ADDR_TARGET, 32'd0);
               write_reg(ADDR_WEIGHT, $urandom_range(1, 65535));
            end
            4: begin
               write_reg(ADDR_MIN_DELTA, $urandom_range(0, 1 << 20));
               write_reg(ADDR_TOLERANCE, $urandom_range(0, 1 << 16));
               write_reg(ADDR_TARGET, $urandom_range(1, 12));
               write_reg(ADDR_WEIGHT, $urandom_range(1, 65535));
            end
            default: begin
               write_reg(ADDR_MIN_DELTA, $urandom_range(0, 1 << 24));
               write_reg(ADDR_TOLERANCE, $urandom_range(0, 1 << 24));
               write_reg(ADDR_TARGET, $urandom_range(2, 40));
               write_reg(ADDR_WEIGHT, $urandom_range(1, 65535));
            end
         endcase
         run_random(set == 2 ? 300 : 270);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests over six register settings; checked %0d results.",
               items_sent, sb.checked);
      $display("Calibrations completed: %0d; field mismatches: %0d.",
               sb.calibrations, sb.errors);
      if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
